@@ sv/knn_pkg.sv @@
// Shared types and constants for the k-nearest-neighbor vote classifier.
// Holds the input and result word layouts, register indexes and opcodes.
// No dependencies.
package knn_pkg;

  localparam int DIST_W   = 26;
  localparam int KREG_W   = 4;
  localparam int PIXCNT_W = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IX_W = 1;
  localparam int CLS_W    = 4;
  localparam int CLS_IW   = 5;

  localparam logic [CFG_IX_W-1:0] CFG_K_NEIGHBORS = 1'd0;
  localparam logic [CFG_IX_W-1:0] CFG_PIXEL_COUNT = 1'd1;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_TRAIN = 1'b1;

  localparam logic [KREG_W-1:0]   K_RESET  = 4'd1;
  localparam logic [PIXCNT_W-1:0] PC_RESET = 11'd784;

  typedef struct packed {
    logic       opcode;
    logic [9:0] pixel_index;
    logic [7:0] pixel_value;
    logic [3:0] image_label;
    logic       last_image;
  } in_word_t;

  typedef struct packed {
    logic [CLS_W-1:0] first_class;
    logic [CLS_W-1:0] second_class;
    logic [CLS_W-1:0] third_class;
  } out_word_t;

endpackage

@@ sv/knn_top3_vote_classifier.sv @@
// Top level of the k-nearest-neighbor classifier with top-three class vote.
// Query store, distance pipeline, sorted neighbor list and vote ranking.
// Depends on knn_pkg.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_data  (opcode, index, value, label, last)
//  out     | output    | out_valid/out_stall | out_data (first, second, third class)
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One word is taken per cycle while in_stall is low. After the final pixel of the
// last image is taken, a result runs through the remaining stages and the output
// register; the accumulate stage and the list insert stage each close their own loop.
// Reset clears control state only; the query store holds no reset value. Input stalls
// only while a result waits at the output and a second result has reached the last stage.
module knn_top3_vote_classifier #(
  parameter int MAX_PIXELS  = 1024,
  parameter int MAX_K       = 8,
  parameter int NUM_CLASSES = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  knn_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output knn_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  logic [knn_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [knn_pkg::CFG_W-1:0]         cfg_wdata
);
  import knn_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int KW = $clog2(MAX_K + 1);
  localparam int VW = $clog2(MAX_K + 1);
  localparam logic [CLS_IW-1:0] NONE_CLS = CLS_IW'(NUM_CLASSES);

  typedef logic [NUM_CLASSES-1:0][VW-1:0] votes_t;

  // configuration registers
  logic [KREG_W-1:0]   cfg_k_r;
  logic [PIXCNT_W-1:0] cfg_pc_r;

  // pipeline control
  logic adv;
  logic in_acc;

  // stage 1: query read
  logic [7:0]  qmem [MAX_PIXELS];
  logic [7:0]  q_r;
  logic        s1_v_r, s1_oob_r, s1_final_r, s1_last_r;
  logic [7:0]  s1_val_r;
  logic [3:0]  s1_lab_r;

  // stage 2: square
  logic        s2_v_r, s2_final_r, s2_last_r;
  logic [15:0] s2_sq_r;
  logic [3:0]  s2_lab_r;

  // stage 3: accumulate
  logic [DIST_W-1:0] dsum_r;
  logic              s3_v_r, s3_last_r;
  logic [DIST_W-1:0] s3_dist_r;
  logic [3:0]        s3_lab_r;

  // neighbor list
  logic [DIST_W-1:0] ldist_r [MAX_K];
  logic [3:0]        llab_r  [MAX_K];
  logic [KW-1:0]     lfill_r;
  logic [DIST_W-1:0] ldist_nxt [MAX_K];
  logic [3:0]        llab_nxt  [MAX_K];
  logic [KW-1:0]     lfill_nxt;

  // vote pipeline
  logic          s4_v_r;
  logic [3:0]    snap_lab_r [MAX_K];
  logic [KW-1:0] snap_fill_r;
  logic          s5_v_r, s6_v_r, s7_v_r;
  votes_t        s5_votes_r, s6_votes_r, s7_votes_r;
  logic [CLS_IW-1:0] s6_c1_r, s7_c1_r, s7_c2_r;

  // output register
  logic      out_valid_r;
  out_word_t out_data_r;

  // effective register values
  logic [KW-1:0]       eff_k;
  logic [PIXCNT_W-1:0] eff_last;
  logic                in_oob;
  logic                in_final;

  // combinational stage values
  logic [7:0]        s1_q, s1_d;
  logic [DIST_W:0]   acc_sum;
  logic [DIST_W-1:0] acc_dist;
  votes_t            votes_nxt;
  logic [CLS_IW-1:0] c1_nxt, c2_nxt, c3_nxt;

  // pick the class with most votes, lower class on ties, none if zero votes
  function automatic logic [CLS_IW-1:0] pick_best(
    input votes_t            v,
    input logic [CLS_IW-1:0] skip_a,
    input logic [CLS_IW-1:0] skip_b
  );
    logic [CLS_IW-1:0] best;
    logic [VW-1:0]     top;
    best = NONE_CLS;
    top  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (CLS_IW'(c) != skip_a && CLS_IW'(c) != skip_b && v[c] > top) begin
        top  = v[c];
        best = CLS_IW'(c);
      end
    end
    return best;
  endfunction

  // stall only when a second result would collide with a waiting one
  assign in_stall = out_valid_r && out_stall && s7_v_r;
  assign adv      = !in_stall;
  assign in_acc   = in_valid && adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r  <= K_RESET;
      cfg_pc_r <= PC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_K_NEIGHBORS: cfg_k_r  <= cfg_wdata[KREG_W-1:0];
        CFG_PIXEL_COUNT: cfg_pc_r <= cfg_wdata[PIXCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable range
  always_comb begin
    if (cfg_k_r == '0) begin
      eff_k = KW'(1);
    end else if (32'(cfg_k_r) > MAX_K) begin
      eff_k = KW'(MAX_K);
    end else begin
      eff_k = KW'(cfg_k_r);
    end
    if (cfg_pc_r == '0) begin
      eff_last = '0;
    end else if (32'(cfg_pc_r) > MAX_PIXELS) begin
      eff_last = PIXCNT_W'(MAX_PIXELS - 1);
    end else begin
      eff_last = cfg_pc_r - PIXCNT_W'(1);
    end
    in_oob   = !(32'(in_data.pixel_index) < MAX_PIXELS);
    in_final = ({1'b0, in_data.pixel_index} == eff_last);
  end

  // query store: write on query load, read on every accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_data.opcode == OP_QUERY && !in_oob) begin
        qmem[AW'(in_data.pixel_index)] <= in_data.pixel_value;
      end
      q_r <= qmem[AW'(in_data.pixel_index)];
    end
  end

  // stage 1: register training pixel fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid && in_data.opcode == OP_TRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_oob_r   <= in_oob;
      s1_final_r <= in_final;
      s1_last_r  <= in_data.last_image;
      s1_val_r   <= in_data.pixel_value;
      s1_lab_r   <= in_data.image_label;
    end
  end

  // stage 2: absolute difference and square
  always_comb begin
    s1_q = s1_oob_r ? 8'd0 : q_r;
    s1_d = (s1_val_r >= s1_q) ? s1_val_r - s1_q : s1_q - s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sq_r    <= 16'(s1_d * s1_d);
      s2_final_r <= s1_final_r;
      s2_last_r  <= s1_last_r;
      s2_lab_r   <= s1_lab_r;
    end
  end

  // stage 3: saturating accumulate, drop the sum after each image
  always_comb begin
    acc_sum  = {1'b0, dsum_r} + (DIST_W + 1)'(s2_sq_r);
    acc_dist = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsum_r <= '0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r && s2_final_r;
      if (s2_v_r) begin
        dsum_r <= s2_final_r ? '0 : acc_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dist_r <= acc_dist;
      s3_last_r <= s2_last_r;
      s3_lab_r  <= s2_lab_r;
    end
  end

  // stage 4: insert into the sorted list, earlier image wins on equal distance
  always_comb begin
    logic [KW-1:0]    fill_eff;
    logic [MAX_K-1:0] le;
    logic [MAX_K-1:0] place;
    fill_eff = (lfill_r > eff_k) ? eff_k : lfill_r;
    for (int j = 0; j < MAX_K; j++) begin
      le[j] = (KW'(j) < fill_eff) && (ldist_r[j] <= s3_dist_r);
    end
    for (int j = 0; j < MAX_K; j++) begin
      place[j] = !le[j] && (KW'(j) < eff_k) && ((j == 0) || le[(j == 0) ? 0 : j - 1]);
      if (le[j]) begin
        ldist_nxt[j] = ldist_r[j];
        llab_nxt[j]  = llab_r[j];
      end else if (place[j] || j == 0) begin
        ldist_nxt[j] = s3_dist_r;
        llab_nxt[j]  = s3_lab_r;
      end else begin
        ldist_nxt[j] = ldist_r[(j == 0) ? 0 : j - 1];
        llab_nxt[j]  = llab_r[(j == 0) ? 0 : j - 1];
      end
    end
    if (|place && fill_eff < eff_k) begin
      lfill_nxt = fill_eff + KW'(1);
    end else begin
      lfill_nxt = fill_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfill_r <= '0;
      s4_v_r  <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r && s3_last_r;
      if (s3_v_r) begin
        lfill_r <= s3_last_r ? '0 : lfill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      for (int j = 0; j < MAX_K; j++) begin
        ldist_r[j] <= ldist_nxt[j];
        llab_r[j]  <= llab_nxt[j];
      end
    end
  end

  // snapshot the final list for voting
  always_ff @(posedge clk) begin
    if (adv && s3_v_r && s3_last_r) begin
      snap_fill_r <= lfill_nxt;
      for (int j = 0; j < MAX_K; j++) begin
        snap_lab_r[j] <= llab_nxt[j];
      end
    end
  end

  // stage 5: count votes per class over the filled entries
  always_comb begin
    logic [MAX_K-1:0] hit;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int i = 0; i < MAX_K; i++) begin
        hit[i] = (KW'(i) < snap_fill_r) && ({1'b0, snap_lab_r[i]} == CLS_IW'(c));
      end
      votes_nxt[c] = VW'($countones(hit));
    end
  end

  // stages 6 to 8: rank the top three classes one per stage
  assign c1_nxt = pick_best(s5_votes_r, NONE_CLS, NONE_CLS);
  assign c2_nxt = pick_best(s6_votes_r, s6_c1_r, NONE_CLS);
  assign c3_nxt = pick_best(s7_votes_r, s7_c1_r, s7_c2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_votes_r <= votes_nxt;
      s6_votes_r <= s5_votes_r;
      s6_c1_r    <= c1_nxt;
      s7_votes_r <= s6_votes_r;
      s7_c1_r    <= s6_c1_r;
      s7_c2_r    <= c2_nxt;
    end
  end

  // output register: load a new result word, else drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s7_v_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s7_v_r) begin
      out_data_r.first_class  <= s7_c1_r[CLS_W-1:0];
      out_data_r.second_class <= s7_c2_r[CLS_W-1:0];
      out_data_r.third_class  <= c3_nxt[CLS_W-1:0];
    end
  end

endmodule
